>>> hw/rtl/assert_macros.svh
// assertion helpers for the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int SLOT_OUT_W = 4;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  localparam logic [2:0] ST_EMPTY   = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_DEAD    = 3'd4;

  localparam logic [1:0] WC_NONE  = 2'd0;
  localparam logic [1:0] WC_SLEEP = 2'd1;
  localparam logic [1:0] WC_KEY   = 2'd2;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_WAKEKEY = 3'd2;
  localparam logic [2:0] ACT_START   = 3'd3;
  localparam logic [2:0] ACT_SLEEP   = 3'd4;
  localparam logic [2:0] ACT_KEYWAIT = 3'd5;
  localparam logic [2:0] ACT_EXIT    = 3'd6;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_NOSW  = 2'd2;
  localparam logic [1:0] STAT_NOKEY = 2'd3;

  typedef struct packed {
    logic [2:0] st;
    logic [1:0] cause;
    logic       user;
  } entry_t;

  localparam entry_t ENTRY_IDLE = '{st: ST_RUNNING, cause: WC_NONE, user: 1'b0};

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    slot_out_t  previous_slot;
    logic       load_kernel_stack;
    slot_out_t  added_slot;
  } result_t;

endpackage

>>> hw/rtl/round_robin_task_scheduler.sv
// items are taken one at a time: item_stall stays high until the last item's result is registered
// reset: synchronous, active high; slot 0 running as idle task, slot count one
// the slot table needs no clearing pass: the slot count and a slot-0 flag give reset values
`timescale 1ns / 1ps

`include "assert_macros.svh"

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  action,
  input  logic [63:0] now,
  input  logic        is_user,
  input  logic [63:0] wake_time,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [3:0]  running_slot,
  output logic        switched,
  output logic [3:0]  previous_slot,
  output logic        load_kernel_stack,
  output logic [3:0]  added_slot
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic          busy;
  logic          done;
  logic          res_free;
  result_t       res;
  logic [SW-1:0] cur_slot;
  logic [CW-1:0] slot_count;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [SW-1:0] ram_raddr;
  entry_t        ram_rdata;
  logic          wake_we;
  logic [63:0]   wake_wdata;
  logic [63:0]   wake_rdata;

  assign item_stall = busy;
  assign res_free   = !result_valid || !result_stall;

  rrts_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .take       (item_valid && !busy),
    .action     (action),
    .now        (now),
    .is_user    (is_user),
    .wake_time  (wake_time),
    .res_free   (res_free),
    .busy       (busy),
    .done       (done),
    .res        (res),
    .cur_slot   (cur_slot),
    .slot_count (slot_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .wake_we    (wake_we),
    .wake_wdata (wake_wdata),
    .wake_rdata (wake_rdata)
  );

  rrts_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrts_ram #(
    .WIDTH(64),
    .DEPTH(SLOTS)
  ) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (cur_slot),
    .wdata (wake_wdata),
    .raddr (ram_raddr),
    .rdata (wake_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status            <= res.status;
      running_slot      <= slot_out_t'(cur_slot);
      switched          <= res.switched;
      previous_slot     <= res.previous_slot;
      load_kernel_stack <= res.load_kernel_stack;
      added_slot        <= res.added_slot;
    end
  end

  `ASSERT_NEXT(a_take_busy, clk, rst, item_valid && !item_stall, item_stall)
  `ASSERT_IMPLIES(a_cur_in_ring, clk, rst, 1'b1, CW'(cur_slot) < slot_count)
  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, slot_count != '0 && slot_count <= CW'(SLOTS))
  `ASSERT_IMPLIES(a_switch_ok, clk, rst, result_valid && switched, status == STAT_OK)

endmodule

>>> hw/rtl/rrts_ram.sv
`timescale 1ns / 1ps

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rrts_ctrl.sv
`timescale 1ns / 1ps

module rrts_ctrl
  import rrts_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int SW    = $clog2(SLOTS),
  parameter int CW    = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [2:0]    action,
  input  logic [63:0]   now,
  input  logic          is_user,
  input  logic [63:0]   wake_time,
  input  logic          res_free,
  output logic          busy,
  output logic          done,
  output result_t       res,
  output logic [SW-1:0] cur_slot,
  output logic [CW-1:0] slot_count,
  output logic          ram_we,
  output logic [SW-1:0] ram_waddr,
  output entry_t        ram_wdata,
  output logic [SW-1:0] ram_raddr,
  input  entry_t        ram_rdata,
  output logic          wake_we,
  output logic [63:0]   wake_wdata,
  input  logic [63:0]   wake_rdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WAKE  = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_DEM   = 4'd3;
  localparam logic [3:0] S_SET   = 4'd4;
  localparam logic [3:0] S_KEY   = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_STRT  = 4'd7;
  localparam logic [3:0] S_STRT2 = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;
  localparam logic [3:0] S_MOD2  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] s,
                                              input logic [CW-1:0] cnt);
    logic [CW-1:0] n;
    begin
      n = CW'(s) + CW'(1);
      return (n >= cnt) ? '0 : n[SW-1:0];
    end
  endfunction

  logic [3:0]    state;
  logic [2:0]    act;
  logic [63:0]   now_q;
  logic          user_q;
  logic [63:0]   wtime_q;
  logic          s0_init;
  logic [CW-1:0] idx;
  logic          pend;
  logic [SW-1:0] pidx;
  logic [SW-1:0] raddr_q;
  logic [SW-1:0] tgt;
  entry_t        tgt_e;
  entry_t        rd_e;
  logic          found;
  logic          key_hit;
  logic          wake_hit;

  assign rd_e = (raddr_q == '0 && !s0_init) ? ENTRY_IDLE : ram_rdata;
  assign found = pend && !(rd_e.st == ST_DEAD || rd_e.st == ST_BLOCKED);
  assign key_hit = pend && rd_e.st == ST_BLOCKED && rd_e.cause == WC_KEY;
  assign wake_hit = pend && rd_e.st == ST_BLOCKED && rd_e.cause == WC_SLEEP &&
                    now_q >= wake_rdata;
  assign busy = (state != S_IDLE);
  assign wake_wdata = wtime_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_slot;
    ram_wdata = rd_e;
    ram_raddr = cur_slot;
    wake_we   = 1'b0;
    done      = 1'b0;
    unique case (state)
      S_WAKE: begin
        ram_raddr = idx[SW-1:0];
        if (wake_hit) begin
          ram_we    = 1'b1;
          ram_waddr = pidx;
          ram_wdata = '{st: ST_READY, cause: WC_NONE, user: rd_e.user};
        end
      end
      S_PICK: begin
        ram_raddr = found ? cur_slot : idx[SW-1:0];
      end
      S_DEM: begin
        if (rd_e.st == ST_RUNNING) begin
          ram_we    = 1'b1;
          ram_wdata = '{st: ST_READY, cause: rd_e.cause, user: rd_e.user};
        end
      end
      S_SET: begin
        ram_we    = 1'b1;
        ram_waddr = tgt;
        ram_wdata = '{st: ST_RUNNING, cause: tgt_e.cause, user: tgt_e.user};
      end
      S_KEY: begin
        ram_raddr = idx[SW-1:0];
        if (key_hit) begin
          ram_we    = 1'b1;
          ram_waddr = pidx;
          ram_wdata = '{st: ST_READY, cause: WC_NONE, user: rd_e.user};
        end
      end
      S_ADD: begin
        ram_we    = (slot_count != CW'(SLOTS));
        ram_waddr = slot_count[SW-1:0];
        ram_wdata = '{st: ST_READY, cause: WC_NONE, user: user_q};
      end
      S_STRT: begin
        ram_raddr = ring_next(cur_slot, slot_count);
      end
      S_MOD2: begin
        ram_we = 1'b1;
        if (act == ACT_EXIT) begin
          ram_wdata = '{st: ST_DEAD, cause: WC_NONE, user: rd_e.user};
        end else if (act == ACT_SLEEP) begin
          ram_wdata = '{st: ST_BLOCKED, cause: WC_SLEEP, user: rd_e.user};
          wake_we   = 1'b1;
        end else begin
          ram_wdata = '{st: ST_BLOCKED, cause: WC_KEY, user: rd_e.user};
        end
      end
      S_DONE: begin
        done = res_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    raddr_q <= ram_raddr;
    if (rst) begin
      state      <= S_IDLE;
      cur_slot   <= '0;
      slot_count <= CW'(1);
      s0_init    <= 1'b0;
      pend       <= 1'b0;
    end else begin
      if (ram_we && ram_waddr == '0) begin
        s0_init <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            act     <= action;
            now_q   <= now;
            user_q  <= is_user;
            wtime_q <= wake_time;
            res     <= '0;
            idx     <= CW'(1);
            pend    <= 1'b0;
            unique case (action)
              ACT_TICK:    state <= S_WAKE;
              ACT_ADD:     state <= S_ADD;
              ACT_WAKEKEY: state <= S_KEY;
              ACT_START:   state <= S_STRT;
              ACT_SLEEP, ACT_KEYWAIT, ACT_EXIT: state <= S_MOD;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_WAKE: begin
          if (idx < slot_count) begin
            pend <= 1'b1;
            pidx <= idx[SW-1:0];
            idx  <= idx + CW'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            idx   <= CW'(ring_next(cur_slot, slot_count));
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (found) begin
            tgt   <= pidx;
            tgt_e <= rd_e;
            pend  <= 1'b0;
            state <= S_DEM;
          end else if (idx[SW-1:0] == cur_slot) begin
            if (pend) begin
              pend <= 1'b0;
            end else begin
              res.status <= STAT_NOSW;
              state      <= S_DONE;
            end
          end else begin
            pend <= 1'b1;
            pidx <= idx[SW-1:0];
            idx  <= CW'(ring_next(idx[SW-1:0], slot_count));
          end
        end
        S_DEM: begin
          state <= S_SET;
        end
        S_SET: begin
          cur_slot              <= tgt;
          res.switched          <= 1'b1;
          res.previous_slot     <= (act == ACT_START) ? '0 : slot_out_t'(cur_slot);
          res.load_kernel_stack <= tgt_e.user;
          state                 <= S_DONE;
        end
        S_KEY: begin
          if (key_hit) begin
            res.status <= STAT_OK;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else if (idx < slot_count) begin
            pend <= 1'b1;
            pidx <= idx[SW-1:0];
            idx  <= idx + CW'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            res.status <= STAT_NOKEY;
            state      <= S_DONE;
          end
        end
        S_ADD: begin
          if (slot_count == CW'(SLOTS)) begin
            res.status <= STAT_FULL;
          end else begin
            res.added_slot <= slot_out_t'(slot_count);
            slot_count     <= slot_count + CW'(1);
          end
          state <= S_DONE;
        end
        S_STRT: begin
          tgt   <= ring_next(cur_slot, slot_count);
          state <= S_STRT2;
        end
        S_STRT2: begin
          tgt_e <= rd_e;
          state <= S_SET;
        end
        S_MOD: begin
          state <= S_MOD2;
        end
        S_MOD2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
